// ===== rtl/sird_pkg.sv =====
package sird_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W         = 6;
    localparam int CHAR_W          = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd61;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
    localparam logic [CHAR_W-1:0] UPPER_A    = 7'h41;
    localparam logic [CHAR_W-1:0] LOWER_A    = 7'h61;

    // digit value to symbol from 0-9, A-Z, a-z
    function automatic logic [CHAR_W-1:0] digit_symbol(input logic [RADIX_W-1:0] d);
        logic [RADIX_W-1:0] dc;
        logic [CHAR_W-1:0]  dx;
        dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
        dx = {1'b0, dc};
        if (dc < 6'd10)
            return ZERO_CHAR + dx;
        else if (dc < 6'd36)
            return UPPER_A + dx - 7'd10;
        else
            return LOWER_A + dx - 7'd36;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN)
            return RADIX_MIN;
        else if (r > RADIX_MAX)
            return RADIX_MAX;
        else
            return r;
    endfunction

endpackage

// ===== rtl/sird_ram.sv =====
module sird_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sird_div.sv =====
module sird_div
    import sird_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [RADIX_W-1:0]     remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [RADIX_W:0]       partial;
    logic [RADIX_W:0]       diff;
    logic                   ge;

    // one restoring step per cycle, quotient shifts in where the dividend shifts out
    assign partial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign ge      = partial >= {1'b0, divisor};
    assign diff    = partial - {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], ge};
            rem_next = ge ? diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/signed_integer_to_radix_digits.sv =====
// sequence: per digit a bit-serial division of the magnitude by the radix in S_START and S_WAIT,
// then S_SIGN for the sign and S_READ, S_LOAD per emitted character when the output is free
// throughput: one item at a time, in_ready only while the sequencer is idle
// reset: asynchronous active low, radix returns to 10, sequencer idle, no request held
module signed_integer_to_radix_digits
    import sird_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [RADIX_W-1:0]     cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   is_last
);

    localparam int AW   = $clog2(VALUE_WIDTH);
    localparam int CNTW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_SIGN,
        S_READ,
        S_LOAD
    } state_t;

    state_t                 state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic                   is_last_reg, is_last_next;

    logic [RADIX_W-1:0]     radix_eff;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [RADIX_W-1:0]     div_rem;
    logic                   ram_we;
    logic                   ram_re;
    logic [CNTW-1:0]        count_dec;
    logic [RADIX_W-1:0]     ram_rdata;
    logic                   out_free;

    assign radix_eff = clamp_radix(radix_reg);
    assign count_dec = count_reg - 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    sird_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (radix_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    sird_ram #(
        .WIDTH(RADIX_W),
        .DEPTH(VALUE_WIDTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(div_rem),
        .re   (ram_re),
        .raddr(count_dec[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        is_last_next   = is_last_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[VALUE_WIDTH-1];
                    mag_next   = value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~value + 1'b1) : value;
                    count_next = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    mag_next   = div_quo;
                    state_next = (div_quo == '0) ? S_SIGN : S_START;
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                    state_next = S_READ;
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = MINUS_CHAR;
                    is_last_next   = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                count_next = count_dec;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_symbol(ram_rdata);
                    is_last_next   = (count_reg == '0);
                    state_next     = (count_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radix_reg     <= RADIX_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                radix_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        is_last_reg  <= is_last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign is_last   = is_last_reg;

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg == '0))
        else $error("digit count not empty while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WAIT))
        else $error("divider finished outside wait state");

    a_wait_has_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (div_busy || div_done))
        else $error("waiting with divider stopped");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(VALUE_WIDTH))
        else $error("digit count beyond store depth");

endmodule
